// ----- rtl/core/lbsa_pkg.sv -----
// lbsa_pkg: shared constants, state type and elaboration-time table functions
// for the log-band spectrum analyzer; no dependencies
package lbsa_pkg;

  localparam int FFT_POINTS_DEF = 1024;
  localparam int NUM_BANDS_DEF  = 64;

  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 2;
  localparam int BAND_W   = 6;
  localparam int LEVEL_W  = 24;
  localparam int DATA_W   = 32;

  localparam logic [CFG_W-1:0] CH_MONO  = 2'd1;
  localparam logic [CFG_W-1:0] CH_RESET = 2'd2;

  localparam longint Q30           = 64'sd1 << 30;
  localparam longint HALF_PI_Q30   = 64'sd1686629713;
  localparam longint LN2_Q30       = 64'sd744261118;
  localparam longint LOG2_20_Q30   = 64'sd4640634956;
  localparam longint LOG2_1000_Q30 = 64'sd10700679395;
  localparam longint SAMPLE_RATE   = 64'sd44100;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WIN_RD,
    ST_WIN_MUL,
    ST_WIN_WR,
    ST_BF_RD,
    ST_BF_MUL,
    ST_BF_SUM,
    ST_BF_WRA,
    ST_BF_WRB,
    ST_BAND_RD,
    ST_BAND_SQ,
    ST_BAND_SUM,
    ST_SQRT,
    ST_OUT
  } st_t;

  // quarter-wave cosine in q30 of angle x (q30 radians), taylor series to x^16
  function automatic longint cos_taylor(longint x);
    longint x2;
    longint term;
    longint sum;
    x2   = x * x / Q30;
    term = Q30;
    sum  = Q30;
    term = -(term * x2 / Q30 / 2);   sum = sum + term;
    term = -(term * x2 / Q30 / 12);  sum = sum + term;
    term = -(term * x2 / Q30 / 30);  sum = sum + term;
    term = -(term * x2 / Q30 / 56);  sum = sum + term;
    term = -(term * x2 / Q30 / 90);  sum = sum + term;
    term = -(term * x2 / Q30 / 132); sum = sum + term;
    term = -(term * x2 / Q30 / 182); sum = sum + term;
    term = -(term * x2 / Q30 / 240); sum = sum + term;
    return sum;
  endfunction

  // fft bin for a band whose log2 frequency y is given in q30
  function automatic longint band_bin(longint y, longint n);
    longint ip;
    longint f;
    longint z;
    longint term;
    longint sum;
    longint freq;
    longint bin;
    ip   = y >>> 30;
    f    = y & (Q30 - 1);
    z    = f * LN2_Q30 / Q30;
    term = Q30;
    sum  = Q30;
    term = term * z / Q30;      sum = sum + term;
    term = term * z / Q30 / 2;  sum = sum + term;
    term = term * z / Q30 / 3;  sum = sum + term;
    term = term * z / Q30 / 4;  sum = sum + term;
    term = term * z / Q30 / 5;  sum = sum + term;
    term = term * z / Q30 / 6;  sum = sum + term;
    term = term * z / Q30 / 7;  sum = sum + term;
    term = term * z / Q30 / 8;  sum = sum + term;
    term = term * z / Q30 / 9;  sum = sum + term;
    term = term * z / Q30 / 10; sum = sum + term;
    term = term * z / Q30 / 11; sum = sum + term;
    term = term * z / Q30 / 12; sum = sum + term;
    if (ip > 20) ip = 20;
    freq = sum << ip;
    bin  = (freq * n / SAMPLE_RATE) >>> 30;
    if (bin >= (n >>> 1)) bin = (n >>> 1) - 1;
    return bin;
  endfunction

endpackage

// ----- rtl/core/lbsa_if.sv -----
// lbsa_in_if / lbsa_out_if: valid-ready channels for audio frames and band results
// depends on lbsa_pkg for field widths
interface lbsa_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [lbsa_pkg::SAMPLE_W-1:0]  left_sample;
  logic signed [lbsa_pkg::SAMPLE_W-1:0]  right_sample;
  logic                                  block_last;
  modport source(output valid, left_sample, right_sample, block_last, input ready);
  modport sink(input valid, left_sample, right_sample, block_last, output ready);
endinterface

interface lbsa_out_if;
  logic                          valid;
  logic                          ready;
  logic [lbsa_pkg::BAND_W-1:0]   band_index;
  logic [lbsa_pkg::LEVEL_W-1:0]  band_level;
  logic                          band_last;
  modport source(output valid, band_index, band_level, band_last, input ready);
  modport sink(input valid, band_index, band_level, band_last, output ready);
endinterface

// ----- rtl/core/log_band_spectrum_analyzer_top.sv -----
// log_band_spectrum_analyzer_top: mono fold, sample store, hann window, radix-2 fft
// and per-band magnitude; depends on lbsa_pkg and lbsa_if
//
// Frames enter on the samples channel, one transaction per cycle while the block
// is idle; each is folded to mono (left alone when channel_count is 1, else the
// floor average of both) and written to the sample memory, frames past
// FFT_POINTS being dropped. The frame flagged block_last starts the analysis and
// ready stays low until the last band result has been taken. The analysis runs
// through one transform memory with a single write port: a window pass writes
// windowed samples in bit-reversed order, then (FFT_POINTS/2)*log2(FFT_POINTS)
// butterflies each go through read, multiply, round, write top and write bottom,
// then each band goes through read, square, scale and a 32-step square root, plus
// the wait for the sink. The memories need no clearing after reset.
module log_band_spectrum_analyzer_top #(
  parameter int FFT_POINTS = lbsa_pkg::FFT_POINTS_DEF,
  parameter int NUM_BANDS  = lbsa_pkg::NUM_BANDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  lbsa_in_if.sink                    samples,
  lbsa_out_if.source                 bands,
  input  logic                       cfg_wen,
  input  logic [lbsa_pkg::CFG_W-1:0] cfg_wdata
);
  import lbsa_pkg::*;

  localparam int LOG2N    = $clog2(FFT_POINTS);
  localparam int AW       = LOG2N;
  localparam int CW       = LOG2N + 1;
  localparam int QUARTER  = FFT_POINTS / 4;
  localparam int QW       = LOG2N - 2;
  localparam int SW       = $clog2(LOG2N);
  localparam int BIW      = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int LSH      = LOG2N - 2;
  localparam int BAND_DEN = (NUM_BANDS > 1) ? NUM_BANDS - 1 : 1;

  // ---------------------------------------------------------------- constant roms
  logic signed [DATA_W-1:0] cos_rom [QUARTER+1];
  logic [AW-1:0]            bin_rom [NUM_BANDS];

  for (genvar g = 0; g <= QUARTER; g++) begin : g_cos
    localparam longint ANGLE = longint'(g) * HALF_PI_Q30 / longint'(QUARTER);
    assign cos_rom[g] = DATA_W'(cos_taylor(ANGLE));
  end
  for (genvar g = 0; g < NUM_BANDS; g++) begin : g_bin
    localparam longint BAND_LOG = LOG2_20_Q30
                                + longint'(g) * LOG2_1000_Q30 / longint'(BAND_DEN);
    assign bin_rom[g] = AW'(band_bin(BAND_LOG, longint'(FFT_POINTS)));
  end

  // ---------------------------------------------------------------- control state
  st_t              state, state_next;
  logic [CFG_W-1:0] channel_count;
  logic [CW-1:0]    sample_count;
  logic [AW-1:0]    idx;          // window position
  logic [AW-2:0]    bfly;         // butterfly number within a stage
  logic [SW-1:0]    stage;
  logic [BAND_W-1:0] band;
  logic [4:0]       sq_cnt;

  logic in_fire;
  assign samples.ready = (state == ST_IDLE);
  assign in_fire       = samples.valid && (state == ST_IDLE);

  // mono fold
  logic signed [SAMPLE_W:0]   pair_sum;
  logic signed [SAMPLE_W-1:0] mono;
  assign pair_sum = SAMPLE_W'(0) + {samples.left_sample[SAMPLE_W-1], samples.left_sample}
                  + {samples.right_sample[SAMPLE_W-1], samples.right_sample};
  assign mono = (channel_count == CH_MONO) ? samples.left_sample
                                           : pair_sum[SAMPLE_W:1];

  // butterfly addressing
  logic [AW-1:0] bf_mask, bf_ext, bf_a, bf_b, bf_k;
  assign bf_mask = (AW'(1) << stage) - AW'(1);
  assign bf_ext  = {1'b0, bfly};
  assign bf_a    = ((bf_ext & ~bf_mask) << 1) | (bf_ext & bf_mask);
  assign bf_b    = bf_a | (AW'(1) << stage);
  assign bf_k    = (bf_ext & bf_mask) << (SW'(LOG2N - 1) - stage);

  logic last_bfly;
  assign last_bfly = (bfly == '1) && (stage == SW'(LOG2N - 1));

  // twiddle rom address: window position or butterfly angle
  logic [AW-1:0] tw_k;
  logic [QW-1:0] tw_r;
  assign tw_k = (state == ST_WIN_RD) ? idx : bf_k;
  assign tw_r = tw_k[QW-1:0];

  // ---------------------------------------------------------------- memories
  logic signed [SAMPLE_W-1:0] sample_mem [FFT_POINTS];
  logic [2*DATA_W-1:0]        tr_mem     [FFT_POINTS];

  logic signed [SAMPLE_W-1:0] samp_rd;
  logic [2*DATA_W-1:0]        rd_a, rd_b;
  logic [AW-1:0]              rd_addr_a;
  logic                       tr_we;
  logic [AW-1:0]              tr_waddr;
  logic [2*DATA_W-1:0]        tr_wdata;

  always_ff @(posedge clk) begin
    if (in_fire && !sample_count[CW-1]) sample_mem[sample_count[AW-1:0]] <= mono;
    samp_rd <= sample_mem[idx];
  end

  assign rd_addr_a = (state == ST_BAND_RD) ? bin_rom[band[BIW-1:0]] : bf_a;

  always_ff @(posedge clk) begin
    if (tr_we) tr_mem[tr_waddr] <= tr_wdata;
    if (state == ST_BF_RD || state == ST_BAND_RD) begin
      rd_a <= tr_mem[rd_addr_a];
      rd_b <= tr_mem[bf_b];
    end
  end

  // ---------------------------------------------------------------- datapath
  logic signed [DATA_W-1:0] rom_a, rom_b;
  logic [1:0]               quad;
  logic                     in_range;

  always_ff @(posedge clk) begin
    if (state == ST_WIN_RD || state == ST_BF_RD) begin
      rom_a    <= cos_rom[{1'b0, tw_r}];
      rom_b    <= cos_rom[(QW+1)'(QUARTER) - {1'b0, tw_r}];
      quad     <= tw_k[AW-1 -: 2];
      in_range <= ({1'b0, idx} < sample_count);
    end
  end

  logic signed [DATA_W-1:0] tw_c, tw_s;
  always_comb begin
    case (quad)
      2'd0:    begin tw_c = rom_a;  tw_s = rom_b;  end
      2'd1:    begin tw_c = -rom_b; tw_s = rom_a;  end
      2'd2:    begin tw_c = -rom_a; tw_s = -rom_b; end
      default: begin tw_c = rom_b;  tw_s = -rom_a; end
    endcase
  end

  // hann weight and windowed product
  logic signed [DATA_W+1:0] w_diff;
  logic signed [DATA_W:0]   w_signed;
  logic signed [SAMPLE_W+DATA_W:0] win_prod, win_round;
  logic                     win_keep;
  assign w_diff   = (DATA_W+2)'(Q30) - (DATA_W+2)'(tw_c);
  assign w_signed = {1'b0, w_diff[DATA_W:1]};

  always_ff @(posedge clk) begin
    if (state == ST_WIN_MUL) begin
      win_prod <= samp_rd * w_signed;
      win_keep <= in_range;
    end
  end
  assign win_round = (win_prod + (SAMPLE_W+DATA_W+1)'(64'sd1 << 28)) >>> 29;

  // butterfly products and rounding
  logic signed [DATA_W-1:0]   a_re, a_im, b_re, b_im;
  logic signed [2*DATA_W-1:0] p0, p1, p2, p3, sum_re, sum_im;
  logic signed [DATA_W-1:0]   t_re, t_im;
  assign a_re = rd_a[2*DATA_W-1:DATA_W];
  assign a_im = rd_a[DATA_W-1:0];
  assign b_re = rd_b[2*DATA_W-1:DATA_W];
  assign b_im = rd_b[DATA_W-1:0];
  assign sum_re = (p0 + p1 + (2*DATA_W)'(64'sd1 << 29)) >>> 30;
  assign sum_im = (p2 - p3 + (2*DATA_W)'(64'sd1 << 29)) >>> 30;

  always_ff @(posedge clk) begin
    if (state == ST_BF_MUL) begin
      p0 <= tw_c * b_re;
      p1 <= tw_s * b_im;
      p2 <= tw_c * b_im;
      p3 <= tw_s * b_re;
    end
    if (state == ST_BF_SUM) begin
      t_re <= sum_re[DATA_W-1:0];
      t_im <= sum_im[DATA_W-1:0];
    end
  end

  // transform write port
  always_comb begin
    tr_we    = 1'b0;
    tr_waddr = bf_a;
    tr_wdata = {a_re + t_re, a_im + t_im};
    case (state)
      ST_WIN_WR: begin
        tr_we    = 1'b1;
        tr_waddr = {<<{idx}};
        tr_wdata = {(win_keep ? win_round[DATA_W-1:0] : DATA_W'(0)), DATA_W'(0)};
      end
      ST_BF_WRA: tr_we = 1'b1;
      ST_BF_WRB: begin
        tr_we    = 1'b1;
        tr_waddr = bf_b;
        tr_wdata = {a_re - t_re, a_im - t_im};
      end
      default: tr_we = 1'b0;
    endcase
  end

  // band magnitude and square root
  logic [2*DATA_W-1:0] sq0, sq1, pow_sum;
  logic [2*DATA_W-1:0] sq_v, sq_res, sq_bit, sq_try;
  logic [2*DATA_W-1:0] sq_v_next, sq_res_next;
  logic [LEVEL_W-1:0]  level;
  assign pow_sum = sq0 + sq1;
  assign sq_try  = sq_res + sq_bit;

  always_comb begin
    if (sq_v >= sq_try) begin
      sq_v_next   = sq_v - sq_try;
      sq_res_next = (sq_res >> 1) + sq_bit;
    end else begin
      sq_v_next   = sq_v;
      sq_res_next = sq_res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_BAND_SQ: begin
        sq0 <= 64'(a_re * a_re);
        sq1 <= 64'(a_im * a_im);
      end
      ST_BAND_SUM: begin
        sq_v   <= ((pow_sum << 3) + pow_sum) >> LSH;
        sq_res <= '0;
        sq_bit <= 64'd1 << 62;
      end
      ST_SQRT: begin
        sq_v   <= sq_v_next;
        sq_res <= sq_res_next;
        sq_bit <= sq_bit >> 2;
        if (sq_cnt == '1)
          level <= (sq_res_next > 64'(LEVEL_MAX)) ? LEVEL_MAX : sq_res_next[LEVEL_W-1:0];
      end
      default: ;
    endcase
  end

  assign bands.valid      = (state == ST_OUT);
  assign bands.band_index = band;
  assign bands.band_level = level;
  assign bands.band_last  = (band == BAND_W'(NUM_BANDS - 1));

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (in_fire && samples.block_last) state_next = ST_WIN_RD;
      ST_WIN_RD:   state_next = ST_WIN_MUL;
      ST_WIN_MUL:  state_next = ST_WIN_WR;
      ST_WIN_WR:   state_next = (idx == AW'(FFT_POINTS - 1)) ? ST_BF_RD : ST_WIN_RD;
      ST_BF_RD:    state_next = ST_BF_MUL;
      ST_BF_MUL:   state_next = ST_BF_SUM;
      ST_BF_SUM:   state_next = ST_BF_WRA;
      ST_BF_WRA:   state_next = ST_BF_WRB;
      ST_BF_WRB:   state_next = last_bfly ? ST_BAND_RD : ST_BF_RD;
      ST_BAND_RD:  state_next = ST_BAND_SQ;
      ST_BAND_SQ:  state_next = ST_BAND_SUM;
      ST_BAND_SUM: state_next = ST_SQRT;
      ST_SQRT:     if (sq_cnt == '1) state_next = ST_OUT;
      ST_OUT: begin
        if (bands.ready)
          state_next = bands.band_last ? ST_IDLE : ST_BAND_RD;
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      channel_count <= CH_RESET;
      sample_count  <= '0;
      idx           <= '0;
      bfly          <= '0;
      stage         <= '0;
      band          <= '0;
      sq_cnt        <= '0;
    end else begin
      state <= state_next;
      if (cfg_wen) channel_count <= cfg_wdata;
      if (in_fire && !sample_count[CW-1]) sample_count <= sample_count + CW'(1);
      if (state == ST_WIN_WR) begin
        idx <= idx + AW'(1);
        if (idx == AW'(FFT_POINTS - 1)) sample_count <= '0;
      end
      if (state == ST_BF_WRB) begin
        bfly <= bfly + (AW-1)'(1);
        if (last_bfly) stage <= '0;
        else if (bfly == '1) stage <= stage + SW'(1);
      end
      if (state == ST_BAND_SUM) sq_cnt <= '0;
      if (state == ST_SQRT) sq_cnt <= sq_cnt + 5'd1;
      if (state == ST_OUT && bands.ready)
        band <= bands.band_last ? '0 : band + BAND_W'(1);
    end
  end

  // ---------------------------------------------------------------- checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count <= CW'(FFT_POINTS))
    else $error("sample count past block size");

  a_plain_frame_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire && !samples.block_last |=> state == ST_IDLE)
    else $error("frame without block end left idle");

  a_block_starts: assert property (@(posedge clk) disable iff (rst)
    in_fire && samples.block_last |=> state == ST_WIN_RD && idx == '0)
    else $error("block end did not start window pass at position zero");

  a_fft_start_clean: assert property (@(posedge clk) disable iff (rst)
    state == ST_WIN_WR && idx == AW'(FFT_POINTS - 1)
      |=> bfly == '0 && stage == '0 && sample_count == '0)
    else $error("fft pass entered with stale counters");

  a_band_one_transaction: assert property (@(posedge clk) disable iff (rst)
    bands.valid && bands.ready && !bands.band_last
      |=> !bands.valid && band == $past(band) + BAND_W'(1))
    else $error("band sequence skipped or repeated");

endmodule

// ----- verif/lbsa_checker.sv -----
// lbsa_checker: watches the sample and band channels of the spectrum analyzer,
// predicts every band result and compares; depends on lbsa_pkg and lbsa_if
`timescale 1ns / 100ps

module lbsa_checker (
  input  logic                       clk,
  input  logic                       rst,
  lbsa_in_if                         samples,
  lbsa_out_if                        bands,
  input  logic                       cfg_wen,
  input  logic [lbsa_pkg::CFG_W-1:0] cfg_wdata,
  output int                         failures,
  output int                         pending
);
  import lbsa_pkg::*;

  localparam int N   = FFT_POINTS_DEF;
  localparam int NB  = NUM_BANDS_DEF;
  localparam int QTR = N / 4;

  typedef struct packed {
    logic [BAND_W-1:0]  idx;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } band_result_t;

  band_result_t      band_queue[$];
  longint            cos_tab[N];
  longint            sin_tab[N];
  int                bin_tab[NB];
  logic [CFG_W-1:0]  chan_cfg;
  logic signed [15:0] mono_store[N];
  int                fill;
  longint            xr[N];
  longint            xi[N];

  // quarter-wave cosine in q30, taylor series
  function automatic longint quarter_cos(longint r);
    longint x, x2, term, acc;
    x    = r * HALF_PI_Q30 / QTR;
    x2   = x * x / Q30;
    term = Q30;
    acc  = Q30;
    for (longint n = 1; n <= 8; n++) begin
      term = -(term * x2 / Q30 / ((2 * n - 1) * (2 * n)));
      acc  = acc + term;
    end
    return acc;
  endfunction

  // log-spaced band to fft bin, clamped below nyquist
  function automatic int pick_bin(longint b);
    longint y, ip, f, z, term, acc, freq, bin;
    y    = LOG2_20_Q30 + b * LOG2_1000_Q30 / (NB - 1);
    ip   = y >>> 30;
    f    = y & (Q30 - 1);
    z    = f * LN2_Q30 / Q30;
    term = Q30;
    acc  = Q30;
    for (longint k = 1; k <= 12; k++) begin
      term = term * z / Q30 / k;
      acc  = acc + term;
    end
    if (ip > 20) ip = 20;
    freq = acc << ip;
    bin  = (freq * N / SAMPLE_RATE) >>> 30;
    if (bin >= N / 2) bin = N / 2 - 1;
    return int'(bin);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bit_w;
    res   = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v   = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  initial begin
    longint ca, sa;
    int q, r;
    failures = 0;
    pending  = 0;
    for (int k = 0; k < N; k++) begin
      q  = k / QTR;
      r  = k % QTR;
      ca = quarter_cos(r);
      sa = quarter_cos(QTR - r);
      case (q)
        0: begin cos_tab[k] = ca;  sin_tab[k] = sa;  end
        1: begin cos_tab[k] = -sa; sin_tab[k] = ca;  end
        2: begin cos_tab[k] = -ca; sin_tab[k] = -sa; end
        default: begin cos_tab[k] = sa; sin_tab[k] = -ca; end
      endcase
    end
    for (int b = 0; b < NB; b++) bin_tab[b] = pick_bin(b);
  end

  // window, bit-reverse, radix-2 butterflies, then one level per band
  task automatic analyze_block();
    int rv, half, step, a, bx;
    longint w, tmp, c, s, br, bi, tr, ti, ar, ai;
    longint unsigned lvl;
    band_result_t res;
    for (int i = 0; i < N; i++) begin
      w     = (Q30 - cos_tab[i]) >>> 1;
      xr[i] = (i < fill) ? ((longint'(mono_store[i]) * w + (64'sd1 <<< 28)) >>> 29) : 0;
      xi[i] = 0;
    end
    fill = 0;
    for (int i = 0; i < N; i++) begin
      rv = 0;
      for (int b = 0; b < 10; b++) rv |= ((i >> b) & 1) << (9 - b);
      if (i < rv) begin
        tmp = xr[i]; xr[i] = xr[rv]; xr[rv] = tmp;
        tmp = xi[i]; xi[i] = xi[rv]; xi[rv] = tmp;
      end
    end
    for (int len = 2; len <= N; len = len << 1) begin
      half = len / 2;
      step = N / len;
      for (int i = 0; i < N; i += len) begin
        for (int j = 0; j < half; j++) begin
          a  = i + j;
          bx = a + half;
          c  = cos_tab[j * step];
          s  = sin_tab[j * step];
          br = xr[bx];
          bi = xi[bx];
          // round half up on every sum of twiddle products
          tr = (c * br + s * bi + (64'sd1 <<< 29)) >>> 30;
          ti = (c * bi - s * br + (64'sd1 <<< 29)) >>> 30;
          xr[bx] = xr[a] - tr;
          xi[bx] = xi[a] - ti;
          xr[a]  = xr[a] + tr;
          xi[a]  = xi[a] + ti;
        end
      end
    end
    for (int b = 0; b < NB; b++) begin
      ar  = xr[bin_tab[b]];
      ai  = xi[bin_tab[b]];
      lvl = int_sqrt(longint'(ar * ar + ai * ai) * 9 / (N / 4));
      if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
      res.idx   = b[BAND_W-1:0];
      res.level = lvl[LEVEL_W-1:0];
      res.last  = (b == NB - 1);
      band_queue.push_back(res);
    end
  endtask

  always @(posedge clk) begin
    int sum;
    logic signed [15:0] mono;
    band_result_t want;
    if (rst) begin
      chan_cfg = CH_RESET;
      fill     = 0;
      band_queue.delete();
    end else begin
      if (cfg_wen) chan_cfg = cfg_wdata;
      if (samples.valid && samples.ready) begin
        sum  = int'(samples.left_sample) + int'(samples.right_sample);
        mono = (chan_cfg == CH_MONO) ? samples.left_sample : 16'(sum >>> 1);
        if (fill < N) begin
          mono_store[fill] = mono;
          fill++;
        end
        if (samples.block_last) analyze_block();
      end
      if (bands.valid && bands.ready) begin
        if (band_queue.size() == 0) begin
          failures++;
          $display("%0t: unexpected band transaction idx %0d level %0h last %0b", $time,
                   bands.band_index, bands.band_level, bands.band_last);
        end else begin
          want = band_queue.pop_front();
          if (bands.band_index !== want.idx) begin
            failures++;
            $display("%0t: band_index expected %0d actual %0d", $time, want.idx,
                     bands.band_index);
          end
          if (bands.band_level !== want.level) begin
            failures++;
            $display("%0t: band_level band %0d expected %0h actual %0h", $time, want.idx,
                     want.level, bands.band_level);
          end
          if (bands.band_last !== want.last) begin
            failures++;
            $display("%0t: band_last band %0d expected %0b actual %0b", $time, want.idx,
                     want.last, bands.band_last);
          end
        end
      end
    end
    pending = band_queue.size();
  end

endmodule

// ----- verif/log_band_spectrum_analyzer_top_tb.sv -----
// log_band_spectrum_analyzer_top_tb: stimulus, handshake idling and verdict for the
// spectrum analyzer; depends on lbsa_pkg, lbsa_if, the block and lbsa_checker
`timescale 1ns / 100ps

module log_band_spectrum_analyzer_top_tb;
  import lbsa_pkg::*;

  logic             clk;
  logic             rst;
  logic             cfg_wen;
  logic [CFG_W-1:0] cfg_wdata;
  int               failures;
  int               pending;
  int               send_idle_pct;
  int               recv_stall_pct;
  int               hold_left;
  logic             hold_req;

  lbsa_in_if  in_ch ();
  lbsa_out_if out_ch ();

  log_band_spectrum_analyzer_top uut (
    .clk       (clk),
    .rst       (rst),
    .samples   (in_ch),
    .bands     (out_ch),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  lbsa_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .samples   (in_ch),
    .bands     (out_ch),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop, far beyond the slowest correct run
  initial begin
    #60000000;
    $display("log_band_spectrum_analyzer_top verification failed");
    $finish;
  end

  // band sink: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_left    = 0;
    end else begin
      if (hold_req) begin
        hold_left = 3000;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // one frame transaction; valid stays up between back-to-back frames
  task automatic send_frame(input logic signed [15:0] l, input logic signed [15:0] r,
                            input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.left_sample  <= l;
    in_ch.right_sample <= r;
    in_ch.block_last   <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // write channel_count once the block has gone quiet
  task automatic drain_and_config(input logic [CFG_W-1:0] value);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (40) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    @(posedge clk);
  endtask

  // mix of full-scale values, small values and random words
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(3))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(255)) - 16'sd128;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_block(input int len);
    for (int i = 1; i <= len; i++) send_frame(pick_sample(), pick_sample(), i == len);
  endtask

  initial begin
    logic [CFG_W-1:0] cfg_seq[4];
    int idle_seq[4];
    int stall_seq[4];
    int sent;
    int len;
    cfg_seq   = '{2'd3, CH_MONO, 2'd0, CH_RESET};
    idle_seq  = '{0, 64, 0, 6};
    stall_seq = '{0, 0, 64, 6};
    rst                = 1'b1;
    hold_req           = 1'b0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    cfg_wen            <= 1'b0;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.left_sample  <= '0;
    in_ch.right_sample <= '0;
    in_ch.block_last   <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset channel setting, extremes, single-frame and short blocks
    send_frame(16'sh7fff, 16'sh7fff, 1'b0);
    send_frame(16'sh8000, 16'sh8000, 1'b0);
    send_frame(16'sh7fff, 16'sh8000, 1'b0);
    send_frame(16'sh8000, 16'sh7fff, 1'b0);
    send_frame(16'sh0000, 16'shffff, 1'b0);
    send_frame(16'sh5555, 16'shaaaa, 1'b0);
    send_frame(16'shaaaa, 16'sh5555, 1'b0);
    send_frame(16'sh0001, 16'sh0000, 1'b1);
    send_frame(16'sh7fff, 16'sh8000, 1'b1);
    for (int i = 0; i < 12; i++)
      send_frame(i[1] ? 16'sh8000 : 16'sh7fff, i[1] ? 16'sh8000 : 16'sh7fff, i == 11);

    for (int ph = 0; ph < 4; ph++) begin
      drain_and_config(cfg_seq[ph]);
      send_idle_pct  = idle_seq[ph];
      recv_stall_pct = stall_seq[ph];
      sent = 0;
      if (ph == 2) hold_req = 1'b1;   // sink stalls while frames keep coming
      while (sent < 45) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
        random_block(len);
        sent += len;
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (failures == 0)
      $display("log_band_spectrum_analyzer_top verification clean");
    else
      $display("log_band_spectrum_analyzer_top verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/lbsa_pkg.sv
rtl/core/lbsa_if.sv
rtl/core/log_band_spectrum_analyzer_top.sv
verif/lbsa_checker.sv
verif/log_band_spectrum_analyzer_top_tb.sv
